// ----- hdl/hpa_pkg.sv -----
`timescale 1ns / 1ps

package hpa_pkg;

	localparam int POOL_SIZE = 1024;
	localparam int IDX_W     = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_EXHAUSTED = 2'd1;
	localparam logic [1:0] STS_INVALID   = 2'd2;

	// free stack access: one read, one pop commit, one push
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             pop_en;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [IDX_W-1:0] wr_data;
	} fs_req_t;

	// active list, slot position and in-use table access
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] al_rd_idx;
		logic [IDX_W-1:0] h_rd_idx;
		logic             al_we;
		logic [IDX_W-1:0] al_wr_idx;
		logic [IDX_W-1:0] al_wr_data;
		logic             sp_we;
		logic [IDX_W-1:0] sp_wr_idx;
		logic [IDX_W-1:0] sp_wr_data;
		logic             iu_we;
		logic [IDX_W-1:0] iu_wr_idx;
		logic             iu_wr_data;
	} trk_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] al_data;
		logic [IDX_W-1:0] sp_data;
		logic             iu_data;
		logic             init_done;
	} trk_rsp_t;

endpackage

// ----- hdl/hpa_req_if.sv -----
`timescale 1ns / 1ps

interface hpa_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [9:0] handle;
	logic [9:0] position;

	modport source (output valid, cmd, handle, position, input ready);
	modport sink (input valid, cmd, handle, position, output ready);
endinterface

// ----- hdl/hpa_rsp_if.sv -----
`timescale 1ns / 1ps

interface hpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [9:0]  result_handle;
	logic [1:0]  status;
	logic [10:0] free_total;
	logic [10:0] active_total;

	modport source (output valid, result_handle, status, free_total, active_total, input ready);
	modport sink (input valid, result_handle, status, free_total, active_total, output ready);
endinterface

// ----- hdl/handle_pool_allocator.sv -----
`timescale 1ns / 1ps

// Handle pool allocator over a pool of 1024 handles. For each command, the accept
// cycle issues reads to the free stack, active list, slot position and in-use
// memories, and the write-back state then checks the read data, writes back and
// loads the result register; a stalled result holds the write-back state, and a new
// command is taken only once the write-back is done. After reset the in-use table is
// swept clear, one entry per cycle, before the first command is taken. Allocate
// returns the top of the free stack or reports the pool exhausted; release swaps the
// last active entry into the freed slot and rejects handles not in use; read returns
// the active list entry at a position.
module handle_pool_allocator (
	input  logic  clk,
	input  logic  arst_n,
	hpa_req_if.sink   req,
	hpa_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                    state_q;
	logic [hpa_pkg::CNT_W-1:0] free_count_q;
	logic [hpa_pkg::CNT_W-1:0] active_count_q;
	logic [1:0]                cmd_s1;
	logic [hpa_pkg::IDX_W-1:0] handle_s1;
	logic [hpa_pkg::IDX_W-1:0] position_s1;

	logic                      out_valid_q;
	logic [hpa_pkg::IDX_W-1:0] result_q;
	logic [1:0]                status_q;
	logic [hpa_pkg::CNT_W-1:0] free_total_q;
	logic [hpa_pkg::CNT_W-1:0] active_total_q;

	hpa_pkg::fs_req_t          fs_req;
	logic [hpa_pkg::IDX_W-1:0] fs_data;
	hpa_pkg::trk_req_t         trk_req;
	hpa_pkg::trk_rsp_t         trk_rsp;

	logic                      accept;
	logic                      go;
	logic [hpa_pkg::IDX_W-1:0] res_handle;
	logic [1:0]                res_status;
	logic [hpa_pkg::CNT_W-1:0] free_next;
	logic [hpa_pkg::CNT_W-1:0] active_next;

	hpa_free_stack u_free_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (fs_req),
		.rd_data (fs_data)
	);

	hpa_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (trk_req),
		.rsp    (trk_rsp)
	);

	assign req.ready = (state_q == S_IDLE) && trk_rsp.init_done;
	assign accept    = req.valid && req.ready;
	// write back only once the result register can take the result
	assign go        = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);

	// sequence accept and write-back cycles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the command for the write-back cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= req.cmd;
			handle_s1   <= req.handle;
			position_s1 <= req.position;
		end
	end

	// issue reads on transfer, decide and write back in the write-back state
	always_comb begin
		fs_req             = '0;
		trk_req            = '0;
		res_handle         = '0;
		res_status         = hpa_pkg::STS_INVALID;
		free_next          = free_count_q;
		active_next        = active_count_q;

		fs_req.rd_en       = accept;
		fs_req.rd_idx      = hpa_pkg::IDX_W'(free_count_q - 1'b1);
		trk_req.rd_en      = accept;
		trk_req.h_rd_idx   = req.handle;
		trk_req.al_rd_idx  = (req.cmd == hpa_pkg::CMD_READ) ? req.position
			: hpa_pkg::IDX_W'(active_count_q - 1'b1);

		case (cmd_s1)
			hpa_pkg::CMD_ALLOC: begin
				if ((free_count_q == '0)
					|| (active_count_q >= hpa_pkg::CNT_W'(hpa_pkg::POOL_SIZE))) begin
					res_status = hpa_pkg::STS_EXHAUSTED;
				end else begin
					res_status         = hpa_pkg::STS_OK;
					res_handle         = fs_data;
					free_next          = free_count_q - 1'b1;
					active_next        = active_count_q + 1'b1;
					fs_req.pop_en      = go;
					trk_req.al_we      = go;
					trk_req.al_wr_idx  = hpa_pkg::IDX_W'(active_count_q);
					trk_req.al_wr_data = fs_data;
					trk_req.sp_we      = go;
					trk_req.sp_wr_idx  = fs_data;
					trk_req.sp_wr_data = hpa_pkg::IDX_W'(active_count_q);
					trk_req.iu_we      = go;
					trk_req.iu_wr_idx  = fs_data;
					trk_req.iu_wr_data = 1'b1;
				end
			end
			hpa_pkg::CMD_RELEASE: begin
				if (trk_rsp.iu_data && (active_count_q != '0)
					&& (free_count_q < hpa_pkg::CNT_W'(hpa_pkg::POOL_SIZE))) begin
					res_status         = hpa_pkg::STS_OK;
					res_handle         = handle_s1;
					free_next          = free_count_q + 1'b1;
					active_next        = active_count_q - 1'b1;
					// move the last active entry into the freed slot
					trk_req.al_we      = go;
					trk_req.al_wr_idx  = trk_rsp.sp_data;
					trk_req.al_wr_data = trk_rsp.al_data;
					trk_req.sp_we      = go;
					trk_req.sp_wr_idx  = trk_rsp.al_data;
					trk_req.sp_wr_data = trk_rsp.sp_data;
					trk_req.iu_we      = go;
					trk_req.iu_wr_idx  = handle_s1;
					trk_req.iu_wr_data = 1'b0;
					fs_req.wr_en       = go;
					fs_req.wr_idx      = hpa_pkg::IDX_W'(free_count_q);
					fs_req.wr_data     = handle_s1;
				end
			end
			hpa_pkg::CMD_READ: begin
				if ({1'b0, position_s1} < active_count_q) begin
					res_status = hpa_pkg::STS_OK;
					res_handle = trk_rsp.al_data;
				end
			end
			default: begin
				res_status = hpa_pkg::STS_INVALID;
			end
		endcase
	end

	// advance the counts on write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q   <= hpa_pkg::CNT_W'(hpa_pkg::POOL_SIZE);
			active_count_q <= '0;
		end else if (go) begin
			free_count_q   <= free_next;
			active_count_q <= active_next;
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result_q       <= res_handle;
			status_q       <= res_status;
			free_total_q   <= free_next;
			active_total_q <= active_next;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.result_handle = result_q;
	assign rsp.status        = status_q;
	assign rsp.free_total    = free_total_q;
	assign rsp.active_total  = active_total_q;

	// every handle is either free or active
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		(free_count_q + active_count_q) == hpa_pkg::CNT_W'(hpa_pkg::POOL_SIZE))
		else $error("free and active counts do not add up to the pool size");

	// a result only appears after a write-back cycle
	a_rose_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EXEC))
		else $error("result appeared without a write-back cycle");

	// a successful allocate takes exactly one handle off the free stack
	a_alloc_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (cmd_s1 == hpa_pkg::CMD_ALLOC) && (res_status == hpa_pkg::STS_OK))
		|=> (free_count_q == $past(free_count_q) - 1'b1))
		else $error("allocate did not pop the free stack");

	// no command is taken while a write-back is pending
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && !go |=> (state_q == S_EXEC) && $stable(cmd_s1))
		else $error("command changed during a stalled write-back");

endmodule

// ----- hdl/hpa_free_stack.sv -----
`timescale 1ns / 1ps

module hpa_free_stack (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hpa_pkg::fs_req_t                 req,
	output logic [hpa_pkg::IDX_W-1:0]        rd_data
);

	logic [hpa_pkg::IDX_W-1:0] mem [hpa_pkg::POOL_SIZE];
	logic [hpa_pkg::IDX_W-1:0] mem_q;
	logic [hpa_pkg::IDX_W-1:0] idx_q;
	logic                      fresh_q;
	// lowest stack depth ever reached; entries below it were never pushed
	logic [hpa_pkg::CNT_W-1:0] low_q;

	// push and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_q <= mem[req.rd_idx];
			idx_q <= req.rd_idx;
		end
	end

	// track the low-water mark and flag reads of untouched entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= hpa_pkg::CNT_W'(hpa_pkg::POOL_SIZE);
			fresh_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				fresh_q <= ({1'b0, req.rd_idx} < low_q);
			end
			if (req.pop_en && ({1'b0, idx_q} < low_q)) begin
				low_q <= {1'b0, idx_q};
			end
		end
	end

	// an untouched entry still holds its own index
	assign rd_data = fresh_q ? idx_q : mem_q;

endmodule

// ----- hdl/hpa_track.sv -----
`timescale 1ns / 1ps

module hpa_track (
	input  logic              clk,
	input  logic              arst_n,
	input  hpa_pkg::trk_req_t req,
	output hpa_pkg::trk_rsp_t rsp
);

	logic [hpa_pkg::IDX_W-1:0] al_mem [hpa_pkg::POOL_SIZE];
	logic [hpa_pkg::IDX_W-1:0] sp_mem [hpa_pkg::POOL_SIZE];
	logic                      iu_mem [hpa_pkg::POOL_SIZE];
	logic [hpa_pkg::IDX_W-1:0] al_q;
	logic [hpa_pkg::IDX_W-1:0] sp_q;
	logic                      iu_q;
	logic [hpa_pkg::CNT_W-1:0] clr_q;
	logic                      init_done;
	logic                      iu_we;
	logic [hpa_pkg::IDX_W-1:0] iu_idx;
	logic                      iu_data;

	assign init_done = (clr_q == hpa_pkg::CNT_W'(hpa_pkg::POOL_SIZE));

	// sweep the in-use table clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!init_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		if (!init_done) begin
			iu_we   = 1'b1;
			iu_idx  = clr_q[hpa_pkg::IDX_W-1:0];
			iu_data = 1'b0;
		end else begin
			iu_we   = req.iu_we;
			iu_idx  = req.iu_wr_idx;
			iu_data = req.iu_wr_data;
		end
	end

	// active list
	always_ff @(posedge clk) begin
		if (req.al_we) begin
			al_mem[req.al_wr_idx] <= req.al_wr_data;
		end
		if (req.rd_en) begin
			al_q <= al_mem[req.al_rd_idx];
		end
	end

	// slot position per handle
	always_ff @(posedge clk) begin
		if (req.sp_we) begin
			sp_mem[req.sp_wr_idx] <= req.sp_wr_data;
		end
		if (req.rd_en) begin
			sp_q <= sp_mem[req.h_rd_idx];
		end
	end

	// in-use flag per handle
	always_ff @(posedge clk) begin
		if (iu_we) begin
			iu_mem[iu_idx] <= iu_data;
		end
		if (req.rd_en) begin
			iu_q <= iu_mem[req.h_rd_idx];
		end
	end

	assign rsp.al_data   = al_q;
	assign rsp.sp_data   = sp_q;
	assign rsp.iu_data   = iu_q;
	assign rsp.init_done = init_done;

endmodule
